// ===== hdl/top_k_score_selector_core_macros.svh =====
`ifndef TOP_K_SCORE_SELECTOR_CORE_MACROS_SVH
`define TOP_K_SCORE_SELECTOR_CORE_MACROS_SVH

// same-cycle implication on clk, off during reset
`define TKSS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("top-k selector check failed");

// next-cycle implication on clk, off during reset
`define TKSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("top-k selector check failed");

`endif

// ===== hdl/tkss_pkg.sv =====
package tkss_pkg;

	localparam int SCORE_W = 32;
	localparam int INDEX_W = 20;
	localparam int RANK_W = 5;
	localparam int KEEP_COUNT_W = 6;
	localparam int MAX_KEEP = 32;
	localparam logic [KEEP_COUNT_W-1:0] KEEP_COUNT_RESET = 6'd10;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [INDEX_W-1:0] item_index;
		logic is_last;
	} cand_word_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] best_score;
		logic [INDEX_W-1:0] best_index;
		logic [RANK_W-1:0] rank;
		logic run_last;
	} res_word_t;

	typedef struct packed {
		logic take;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic go_drain;
		logic remain_one;
	} stat_t;

endpackage

// ===== hdl/top_k_score_selector_core.sv =====
// order: a taken is_last word with items held moves the control to the drain state,
// whose steps load the output register, one result per cycle while res_ready is high
// throughput: one item per cycle between runs; in a run cand_ready stays low until the
// last result is loaded into the single output register fed from the head cell
// reset: asynchronous, active low; clears the held count and sets keep_count to 10
module top_k_score_selector_core #(
	parameter int MaxKeep = tkss_pkg::MAX_KEEP
) (
	input logic clk,
	input logic arst_n,
	input logic cand_valid,
	output logic cand_ready,
	input tkss_pkg::cand_word_t cand,
	output logic res_valid,
	input logic res_ready,
	output tkss_pkg::res_word_t res,
	input logic keep_count_we,
	input logic [tkss_pkg::KEEP_COUNT_W-1:0] keep_count_wdata
);

	tkss_pkg::cmd_t cmd;
	tkss_pkg::stat_t stat;

	tkss_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cand_valid(cand_valid),
		.cand_ready(cand_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.stat(stat),
		.cmd(cmd)
	);

	tkss_datapath #(
		.MaxKeep(MaxKeep)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cand(cand),
		.keep_count_we(keep_count_we),
		.keep_count_wdata(keep_count_wdata),
		.cmd(cmd),
		.stat(stat),
		.res(res)
	);

endmodule

// ===== hdl/tkss_datapath.sv =====
module tkss_datapath #(
	parameter int MaxKeep = tkss_pkg::MAX_KEEP
) (
	input logic clk,
	input logic arst_n,
	input tkss_pkg::cand_word_t cand,
	input logic keep_count_we,
	input logic [tkss_pkg::KEEP_COUNT_W-1:0] keep_count_wdata,
	input tkss_pkg::cmd_t cmd,
	output tkss_pkg::stat_t stat,
	output tkss_pkg::res_word_t res
);

	localparam int CntW = $clog2(MaxKeep + 1);

	logic [tkss_pkg::KEEP_COUNT_W-1:0] keep_count_q;
	logic [CntW-1:0] k_eff;
	logic [CntW-1:0] held_count_q;
	logic [CntW-1:0] count_ins;
	logic [CntW-1:0] n_out_next;
	logic [CntW-1:0] remain_q;
	logic [CntW-1:0] rank_q;
	logic signed [tkss_pkg::SCORE_W-1:0] score_q [MaxKeep];
	logic [tkss_pkg::INDEX_W-1:0] index_q [MaxKeep];
	logic signed [tkss_pkg::SCORE_W-1:0] score_dn [MaxKeep];
	logic [tkss_pkg::INDEX_W-1:0] index_dn [MaxKeep];
	logic signed [tkss_pkg::SCORE_W-1:0] score_up [MaxKeep];
	logic [tkss_pkg::INDEX_W-1:0] index_up [MaxKeep];
	logic [MaxKeep-1:0] held_vld;
	logic [MaxKeep-1:0] ge;
	logic [MaxKeep-1:0] ge_up;
	logic full;
	logic lt_any;
	logic ins;
	tkss_pkg::res_word_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= tkss_pkg::KEEP_COUNT_RESET;
		end else if (keep_count_we) begin
			keep_count_q <= keep_count_wdata;
		end
	end

	always_comb begin
		if (int'(keep_count_q) > MaxKeep) begin
			k_eff = CntW'(MaxKeep);
		end else begin
			k_eff = CntW'(keep_count_q);
		end
	end

	// per-cell compare against the incoming score
	for (genvar i = 0; i < MaxKeep; i++) begin : g_cmp
		assign held_vld[i] = CntW'(i) < held_count_q;
		assign ge[i] = held_vld[i] && (score_q[i] >= cand.score);
	end

	assign ge_up = MaxKeep'({ge, 1'b1});
	assign full = held_count_q >= k_eff;
	assign lt_any = |(held_vld & ~ge);
	assign ins = !full || ((k_eff != '0) && lt_any);
	assign count_ins = (ins && !full) ? held_count_q + CntW'(1) : held_count_q;
	assign n_out_next = (count_ins < k_eff) ? count_ins : k_eff;

	assign stat.go_drain = cand.is_last && (n_out_next != '0);
	assign stat.remain_one = remain_q == CntW'(1);

	// insertion chain: cells below the slot shift down, drain shifts up
	for (genvar i = 0; i < MaxKeep; i++) begin : g_cell
		if (i > 0) begin : g_dn
			assign score_dn[i] = score_q[i-1];
			assign index_dn[i] = index_q[i-1];
		end else begin : g_dn_head
			assign score_dn[i] = cand.score;
			assign index_dn[i] = cand.item_index;
		end
		if (i < MaxKeep - 1) begin : g_up
			assign score_up[i] = score_q[i+1];
			assign index_up[i] = index_q[i+1];
		end else begin : g_up_tail
			assign score_up[i] = score_q[i];
			assign index_up[i] = index_q[i];
		end

		always_ff @(posedge clk) begin
			if (cmd.take && ins && !ge[i]) begin
				if (ge_up[i]) begin
					score_q[i] <= cand.score;
					index_q[i] <= cand.item_index;
				end else begin
					score_q[i] <= score_dn[i];
					index_q[i] <= index_dn[i];
				end
			end else if (cmd.step) begin
				score_q[i] <= score_up[i];
				index_q[i] <= index_up[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			remain_q <= '0;
			rank_q <= '0;
		end else if (cmd.take) begin
			held_count_q <= cand.is_last ? '0 : count_ins;
			remain_q <= cand.is_last ? n_out_next : '0;
			rank_q <= '0;
		end else if (cmd.step) begin
			remain_q <= remain_q - CntW'(1);
			rank_q <= rank_q + CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			res_q.best_score <= score_q[0];
			res_q.best_index <= index_q[0];
			res_q.rank <= tkss_pkg::RANK_W'(rank_q);
			res_q.run_last <= stat.remain_one;
		end
	end

	assign res = res_q;

endmodule

// ===== hdl/tkss_ctrl.sv =====
module tkss_ctrl (
	input logic clk,
	input logic arst_n,
	input logic cand_valid,
	output logic cand_ready,
	output logic res_valid,
	input logic res_ready,
	input tkss_pkg::stat_t stat,
	output tkss_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic state_next;
	logic res_valid_q;

	assign cand_ready = state_q == ST_IDLE;
	assign cmd.take = cand_valid && cand_ready;
	assign cmd.step = (state_q == ST_DRAIN) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.take && stat.go_drain) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cmd.step && stat.remain_one) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.step) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/tkss_checker.sv =====
`include "top_k_score_selector_core_macros.svh"

module tkss_checker (
	input logic clk,
	input logic arst_n,
	input logic cand_ready,
	input logic res_valid,
	input logic res_ready,
	input tkss_pkg::res_word_t res
);

	logic mid_run_take;

	assign mid_run_take = res_valid && res_ready && !res.run_last;

	`TKSS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
	`TKSS_ASSERT_NEXT(a_run_continues, mid_run_take, res_valid && (res.rank == $past(res.rank) + 5'd1))
	`TKSS_ASSERT_NEXT(a_descending, mid_run_take, res.best_score <= $past(res.best_score))
	`TKSS_ASSERT_NOW(a_no_take_mid_run, res_valid && !res.run_last, !cand_ready)

endmodule

bind top_k_score_selector_core tkss_checker u_tkss_checker (.*);
